/* hw/rtl/lru_cache_hit_counter_assert.svh */
// Assertion macros for the LRU cache hit counter RTL.
// Expects i_clk and i_rst_n in the scope of the module that uses them.
`ifndef LRU_CACHE_HIT_COUNTER_ASSERT_SVH
`define LRU_CACHE_HIT_COUNTER_ASSERT_SVH
`ifndef SYNTHESIS
// Property holds on every clock edge outside reset
`define LCC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);
// Consequent holds in the same cycle as the antecedent
`define LCC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Consequent holds in the cycle after the antecedent
`define LCC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define LCC_ASSERT(lbl, prop, msg)
`define LCC_ASSERT_IMP(lbl, ante, cons, msg)
`define LCC_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

/* hw/rtl/lcc_pkg.sv */
// Shared types and constants of the LRU cache hit counter.
// No dependencies; used by every other file of the block but the assertion header.
package lcc_pkg;

    // Default sizes
    localparam int MAX_ENTRIES_DEF = 16;
    localparam int KEY_BITS_DEF    = 32;

    // Fixed field widths
    localparam int CAP_BITS      = 5;
    localparam int COUNT_BITS    = 16;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 16;

    // Register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_CAPACITY = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HIT_GOAL = 2'd1;

    // Register reset values
    localparam logic [CAP_BITS-1:0]   CAP_RESET  = 5'd16;
    localparam logic [COUNT_BITS-1:0] GOAL_RESET = 16'd0;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_UPD
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic load;    // capture the input beat
        logic look;    // run the tag compare and register the hits
        logic commit;  // apply the update and load the result register
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic out_free;  // result register can take a new beat this cycle
    } t_stat;

endpackage

/* hw/rtl/lcc_in_if.sv */
// Access channel of the LRU cache hit counter: valid/ready plus key and run mark.
// Depends on lcc_pkg for the default key width.
interface lcc_in_if #(
    parameter int KEY_BITS = lcc_pkg::KEY_BITS_DEF
);
    logic                valid;
    logic                ready;
    logic [KEY_BITS-1:0] access_key;
    logic                last_in_run;

    modport source (output valid, output access_key, output last_in_run, input ready);
    modport sink   (input valid, input access_key, input last_in_run, output ready);
endinterface

/* hw/rtl/lcc_out_if.sv */
// Result channel of the LRU cache hit counter: valid/ready plus result fields.
// Depends on lcc_pkg for the default key and count widths.
interface lcc_out_if #(
    parameter int KEY_BITS = lcc_pkg::KEY_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic                          hit;
    logic                          evicted_valid;
    logic [KEY_BITS-1:0]           evicted_key;
    logic [lcc_pkg::COUNT_BITS-1:0] hit_total;
    logic                          goal_met;
    logic                          run_done;

    modport source (
        output valid, output hit, output evicted_valid, output evicted_key,
        output hit_total, output goal_met, output run_done, input ready
    );
    modport sink (
        input valid, input hit, input evicted_valid, input evicted_key,
        input hit_total, input goal_met, input run_done, output ready
    );
endinterface

/* hw/rtl/lcc_ctrl.sv */
// Sequencer of the LRU cache hit counter: accept, look up, commit.
// Depends on lcc_pkg for the state, command and status types.
module lcc_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  lcc_pkg::t_stat i_stat,
    output lcc_pkg::t_cmd  o_cmd
);

    lcc_pkg::t_state r_state;
    lcc_pkg::t_state n_state;
    logic            w_accept;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lcc_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands; take a beat while idle or in the commit cycle
    always_comb begin
        n_state      = r_state;
        o_in_ready   = 1'b0;
        o_cmd.look   = 1'b0;
        o_cmd.commit = 1'b0;
        case (r_state)
            lcc_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
            end
            lcc_pkg::S_LOOK: begin
                o_cmd.look = 1'b1;
            end
            lcc_pkg::S_UPD: begin
                o_in_ready   = i_stat.out_free;
                o_cmd.commit = i_stat.out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
        w_accept   = i_in_valid && o_in_ready;
        o_cmd.load = w_accept;
        case (r_state)
            lcc_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_state = lcc_pkg::S_LOOK;
                end
            end
            lcc_pkg::S_LOOK: begin
                n_state = lcc_pkg::S_UPD;
            end
            lcc_pkg::S_UPD: begin
                if (i_stat.out_free) begin
                    n_state = w_accept ? lcc_pkg::S_LOOK : lcc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = lcc_pkg::S_IDLE;
            end
        endcase
    end

endmodule

/* hw/rtl/lcc_datapath.sv */
// Tag store, recency ranks, hit counter, config registers and result register.
// Depends on lcc_pkg, lcc_out_if and lru_cache_hit_counter_assert.svh.
`include "lru_cache_hit_counter_assert.svh"
module lcc_datapath #(
    parameter int MAX_ENTRIES = lcc_pkg::MAX_ENTRIES_DEF,
    parameter int KEY_BITS    = lcc_pkg::KEY_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [lcc_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [lcc_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    input  logic [KEY_BITS-1:0]               i_access_key,
    input  logic                              i_last_in_run,
    input  lcc_pkg::t_cmd                     i_cmd,
    output lcc_pkg::t_stat                    o_stat,
    lcc_out_if.source                         o_out
);

    localparam int RW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int OW = $clog2(MAX_ENTRIES + 1);
    localparam int CW = (OW > lcc_pkg::CAP_BITS) ? OW : lcc_pkg::CAP_BITS;
    localparam int NB = lcc_pkg::COUNT_BITS;

    // Config registers
    logic [lcc_pkg::CAP_BITS-1:0] r_cap;
    logic [NB-1:0]                r_goal;

    // Cache state
    logic [KEY_BITS-1:0]    r_tag   [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] r_valid;
    logic [RW-1:0]          r_rank  [MAX_ENTRIES];
    logic [OW-1:0]          r_occ;
    logic [NB-1:0]          r_count;

    // Captured beat
    logic [KEY_BITS-1:0] r_key;
    logic                r_last;

    // Lookup results
    logic [MAX_ENTRIES-1:0] r_hit_oh;
    logic [MAX_ENTRIES-1:0] r_lru_oh;
    logic [MAX_ENTRIES-1:0] r_free_oh;
    logic [RW-1:0]          r_hit_rank;
    logic [KEY_BITS-1:0]    r_ev_tag;

    // Result register
    logic                r_out_valid;
    logic                r_out_hit;
    logic                r_out_ev_valid;
    logic [KEY_BITS-1:0] r_out_ev_key;
    logic [NB-1:0]       r_out_total;
    logic                r_out_goal;
    logic                r_out_done;

    // Lookup combinational
    logic [MAX_ENTRIES-1:0] w_match;
    logic [MAX_ENTRIES-1:0] w_lru;
    logic [MAX_ENTRIES-1:0] w_free;
    logic [MAX_ENTRIES-1:0] w_hit_oh;
    logic [MAX_ENTRIES-1:0] w_lru_oh;
    logic [MAX_ENTRIES-1:0] w_free_oh;
    logic [RW-1:0]          w_hit_rank;
    logic [KEY_BITS-1:0]    w_ev_tag;

    // Update combinational
    logic                   w_hit;
    logic                   w_full;
    logic                   w_evict;
    logic [CW-1:0]          w_eff_cap;
    logic [CW-1:0]          w_cap_ext;
    logic [MAX_ENTRIES-1:0] w_ins_oh;
    logic [NB-1:0]          w_count_inc;
    logic [NB-1:0]          n_count;
    logic [OW-1:0]          n_occ;
    logic [MAX_ENTRIES-1:0] n_valid;
    logic [RW-1:0]          n_rank  [MAX_ENTRIES];
    logic                   w_taken;

    // Compare every lane, then keep the lowest matching lane of each kind
    always_comb begin
        w_hit_rank = '0;
        w_ev_tag   = '0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            w_match[i] = r_valid[i] && (r_tag[i] == r_key);
            w_lru[i]   = r_valid[i] && (r_rank[i] == '0);
            w_free[i]  = !r_valid[i];
        end
        w_hit_oh  = w_match & (~w_match + 1'b1);
        w_lru_oh  = w_lru & (~w_lru + 1'b1);
        w_free_oh = w_free & (~w_free + 1'b1);
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            w_hit_rank = w_hit_rank | (r_rank[i] & {RW{w_hit_oh[i]}});
            w_ev_tag   = w_ev_tag | (r_tag[i] & {KEY_BITS{w_lru_oh[i]}});
        end
    end

    // Clamp capacity to one .. MAX_ENTRIES
    always_comb begin
        w_cap_ext = CW'(r_cap);
        if (r_cap == '0) begin
            w_eff_cap = CW'(1);
        end else if (w_cap_ext > CW'(MAX_ENTRIES)) begin
            w_eff_cap = CW'(MAX_ENTRIES);
        end else begin
            w_eff_cap = w_cap_ext;
        end
        w_full  = CW'(r_occ) >= w_eff_cap;
        w_hit   = |r_hit_oh;
        w_evict = !w_hit && w_full && (|r_lru_oh);
        if (w_hit) begin
            w_ins_oh = '0;
        end else if (w_evict) begin
            w_ins_oh = r_lru_oh;
        end else begin
            w_ins_oh = r_free_oh;
        end
        w_count_inc = (w_hit && (r_count != '1)) ? r_count + 1'b1 : r_count;
        n_count     = r_last ? '0 : w_count_inc;
    end

    // Recency update: promote the hit or inserted lane, age the ones above the gap
    always_comb begin
        n_valid = r_valid;
        n_occ   = r_occ;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            n_rank[i] = r_rank[i];
        end
        if (w_hit) begin
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                if (r_hit_oh[i]) begin
                    n_rank[i] = RW'(r_occ - 1'b1);
                end else if (r_valid[i] && (r_rank[i] > r_hit_rank)) begin
                    n_rank[i] = r_rank[i] - 1'b1;
                end
            end
        end else if (w_evict) begin
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                if (r_lru_oh[i]) begin
                    n_rank[i] = RW'(r_occ - 1'b1);
                end else if (r_valid[i] && (r_rank[i] != '0)) begin
                    n_rank[i] = r_rank[i] - 1'b1;
                end
            end
        end else if (|r_free_oh) begin
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                if (r_free_oh[i]) begin
                    n_rank[i]  = RW'(r_occ);
                    n_valid[i] = 1'b1;
                end
            end
            n_occ = r_occ + 1'b1;
        end
        // Drop the whole cache at the end of a run
        if (r_last) begin
            n_valid = '0;
            n_occ   = '0;
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                n_rank[i] = '0;
            end
        end
    end

    assign w_taken         = r_out_valid && o_out.ready;
    assign o_stat.out_free = !r_out_valid || o_out.ready;

    // Control state, config and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap       <= lcc_pkg::CAP_RESET;
            r_goal      <= lcc_pkg::GOAL_RESET;
            r_valid     <= '0;
            r_occ       <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                r_rank[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    lcc_pkg::CFG_CAPACITY: r_cap  <= i_cfg_data[lcc_pkg::CAP_BITS-1:0];
                    lcc_pkg::CFG_HIT_GOAL: r_goal <= i_cfg_data[NB-1:0];
                    default: begin
                    end
                endcase
            end
            if (i_cmd.commit) begin
                r_valid <= n_valid;
                r_occ   <= n_occ;
                r_count <= n_count;
                for (int i = 0; i < MAX_ENTRIES; i++) begin
                    r_rank[i] <= n_rank[i];
                end
            end
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (w_taken) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key  <= i_access_key;
            r_last <= i_last_in_run;
        end
        if (i_cmd.look) begin
            r_hit_oh   <= w_hit_oh;
            r_lru_oh   <= w_lru_oh;
            r_free_oh  <= w_free_oh;
            r_hit_rank <= w_hit_rank;
            r_ev_tag   <= w_ev_tag;
        end
        if (i_cmd.commit) begin
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                if (w_ins_oh[i]) begin
                    r_tag[i] <= r_key;
                end
            end
            r_out_hit      <= w_hit;
            r_out_ev_valid <= w_evict;
            r_out_ev_key   <= w_evict ? r_ev_tag : '0;
            r_out_total    <= w_count_inc;
            r_out_goal     <= w_count_inc >= r_goal;
            r_out_done     <= r_last;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.hit           = r_out_hit;
    assign o_out.evicted_valid = r_out_ev_valid;
    assign o_out.evicted_key   = r_out_ev_key;
    assign o_out.hit_total     = r_out_total;
    assign o_out.goal_met      = r_out_goal;
    assign o_out.run_done      = r_out_done;

    // Occupancy tracks the valid lanes and never passes the entry count
    `LCC_ASSERT(a_occ_matches_valid, $countones(r_valid) == int'(r_occ), "occupancy mismatch")
    `LCC_ASSERT(a_occ_bound, int'(r_occ) <= MAX_ENTRIES, "occupancy above entry count")
    // A run end leaves an empty cache and a zero count
    `LCC_ASSERT_NXT(a_run_clear, i_cmd.commit && r_last, (r_valid == '0) && (r_count == '0),
        "cache not cleared after run end")
    // A hit never evicts
    `LCC_ASSERT_IMP(a_hit_no_evict, r_out_valid && r_out_hit, !r_out_ev_valid,
        "eviction reported on a hit")

endmodule

/* hw/rtl/lru_cache_hit_counter.sv */
// LRU cache hit counter, top level: sequencer plus datapath.
// Depends on lcc_pkg, lcc_in_if, lcc_out_if, lcc_ctrl and lcc_datapath.
//
// Usage:
//   i_in carries one access per beat: access_key and last_in_run.
//   o_out returns exactly one result beat per access, in order: hit,
//   evicted_valid, evicted_key, hit_total, goal_met and run_done.
//   The write port (i_cfg_we, i_cfg_idx, i_cfg_data) sets capacity (index 0)
//   and hit_goal (index 1); write it only while no access is in flight.
// Timing:
//   After it is accepted, an access goes through the parallel tag compare
//   over all entries (S_LOOK), then the recency and counter update (S_UPD),
//   which also loads the result register.
//   A new access is accepted in the update cycle, so a new access can enter
//   while the last one commits, as long as the result side keeps up.
// Reset:
//   Cache empty, hit count zero, capacity 16, hit_goal 0. Accesses are taken
//   straight out of reset.
// Stall:
//   The result register holds until taken. One more access may be taken and
//   looked up meanwhile; its update then waits, and no further access is
//   accepted until the result register frees up.
module lru_cache_hit_counter #(
    parameter int MAX_ENTRIES = lcc_pkg::MAX_ENTRIES_DEF,
    parameter int KEY_BITS    = lcc_pkg::KEY_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [lcc_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [lcc_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    lcc_in_if.sink                            i_in,
    lcc_out_if.source                         o_out
);

    lcc_pkg::t_cmd  w_cmd;
    lcc_pkg::t_stat w_stat;
    logic           w_in_ready;

    assign i_in.ready = w_in_ready;

    // Sequencer
    lcc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // Cache, counter and result register
    lcc_datapath #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .KEY_BITS    (KEY_BITS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_access_key  (i_in.access_key),
        .i_last_in_run (i_in.last_in_run),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .o_out         (o_out)
    );

endmodule
